### hw/rtl/pct_pkg.sv
// Package for the key-cache table: command codes, entry layout, field widths
// and controller states. It depends on nothing.
package pct_pkg;

    localparam int ADDR_W = 48;
    localparam int KEY_W  = 64;
    localparam int SLOT_W = 4;

    // Operation codes carried in the cmd field of an input beat.
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    // One row of the entry memory.
    typedef struct packed {
        logic              used;
        logic [KEY_W-1:0]  key_high;
        logic [KEY_W-1:0]  key_low;
        logic [ADDR_W-1:0] addr;
    } t_entry;

    // Controller states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } t_state;

endpackage

### hw/rtl/pct_if.sv
// Handshake interfaces for the command channel and the result channel.
// They depend on the field widths in pct_pkg.

interface pct_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 cmd;
    logic [pct_pkg::ADDR_W-1:0] station_addr;
    logic [pct_pkg::KEY_W-1:0]  key_high;
    logic [pct_pkg::KEY_W-1:0]  key_low;

    modport source (output valid, output cmd, output station_addr,
                    output key_high, output key_low, input ready);
    modport sink   (input valid, input cmd, input station_addr,
                    input key_high, input key_low, output ready);
endinterface

interface pct_out_if;
    logic                       valid;
    logic                       ready;
    logic                       accepted;
    logic                       matched;
    logic [pct_pkg::SLOT_W-1:0] slot;

    modport source (output valid, output accepted, output matched,
                    output slot, input ready);
    modport sink   (input valid, input accepted, input matched,
                    input slot, output ready);
endinterface

### hw/rtl/pct_entry_store.sv
// Entry memory of the key-cache table with one registered read port and one
// write port. Per-row written bits make unwritten rows read as zero.
// It depends on pct_pkg for the entry layout.
module pct_entry_store #(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [IW-1:0]   i_rd_idx,
    output pct_pkg::t_entry o_rd_data,
    input  logic            i_wr_en,
    input  logic [IW-1:0]   i_wr_idx,
    input  pct_pkg::t_entry i_wr_data,
    input  logic            i_flush
);

    pct_pkg::t_entry    r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_row_ok;
    pct_pkg::t_entry    r_rd_data;
    logic               r_rd_ok;

    // Memory array: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    // Rows count as written only after a write since the last reset or flush.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_flush) begin
                r_row_ok <= '0;
            end else if (i_wr_en) begin
                r_row_ok[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_row_ok[i_rd_idx];
            end
        end
    end

    // An unwritten row reads as the cleared entry.
    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

### hw/rtl/pmkid_cache_table_top.sv
// Top level of the key-cache table: command intake, sequential address
// search, write-back and result register. It depends on pct_pkg, pct_if
// and pct_entry_store.
//
//  Channel  Port   Dir  Beat contents
//  command  i_in   in   cmd, station_addr, key_high, key_low
//  result   o_out  out  accepted, matched, slot
//
// An add or remove searches every row on a miss and stops early on a hit:
// the search reads one memory row per cycle through the single read port.
// Flush, no-op commands and adds of the zero address skip the search and
// go straight to the final state. One command is in work at a time; the next
// may be taken while a result still waits in the output register. Reset and
// flush clear the table at once through per-row written bits, with no
// clearing pass. A stalled result holds the controller in its final state.
module pmkid_cache_table_top #(
    parameter int ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pct_in_if.sink       i_in,
    pct_out_if.source    o_out
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    pct_pkg::t_state r_state, n_state;
    pct_pkg::t_cmd   r_cmd;
    logic [pct_pkg::ADDR_W-1:0] r_addr;
    logic [pct_pkg::KEY_W-1:0]  r_khi, r_klo;
    logic [pct_pkg::KEY_W-1:0]  r_hit_khi, r_hit_klo;
    logic [IW-1:0]   r_idx, r_cmp_idx, r_hit_idx, r_ptr;
    logic            r_all_issued, r_cmp_vld, r_hit;
    logic            r_out_valid, r_out_acc, r_out_match;
    logic [pct_pkg::SLOT_W-1:0] r_out_slot;

    logic            in_beat, out_free, hit_now, last_cmp, skip_search;
    logic            rd_en, wr_en, flush, finish;
    logic [IW-1:0]   wr_idx;
    pct_pkg::t_entry wr_data, rd_data;
    logic            res_acc, res_match;
    logic [IW-1:0]   res_idx;
    logic            ptr_load;
    logic [IW-1:0]   ptr_next;

    assign in_beat  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign hit_now  = r_cmp_vld && (rd_data.addr == r_addr);
    assign last_cmp = r_cmp_vld && (r_cmp_idx == LAST);
    assign finish   = (r_state == pct_pkg::ST_FINISH) && out_free;

    // Commands that need no search go straight to the final state.
    assign skip_search =
        (pct_pkg::t_cmd'(i_in.cmd) == pct_pkg::CMD_FLUSH) ||
        (pct_pkg::t_cmd'(i_in.cmd) == pct_pkg::CMD_NOP) ||
        ((pct_pkg::t_cmd'(i_in.cmd) == pct_pkg::CMD_ADD) && (i_in.station_addr == '0));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pct_pkg::ST_IDLE: begin
                if (in_beat) begin
                    n_state = skip_search ? pct_pkg::ST_FINISH : pct_pkg::ST_SEARCH;
                end
            end
            pct_pkg::ST_SEARCH: begin
                if (hit_now || last_cmp) begin
                    n_state = pct_pkg::ST_FINISH;
                end
            end
            pct_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = pct_pkg::ST_IDLE;
                end
            end
            default: n_state = pct_pkg::ST_IDLE;
        endcase
    end

    // State outputs: memory reads during the search, write-back and result at the end.
    always_comb begin
        rd_en     = (r_state == pct_pkg::ST_SEARCH) && !r_all_issued;
        wr_en     = 1'b0;
        wr_idx    = r_hit_idx;
        wr_data   = '0;
        flush     = 1'b0;
        res_acc   = 1'b0;
        res_match = 1'b0;
        res_idx   = '0;
        ptr_load  = 1'b0;
        ptr_next  = r_ptr;
        if (finish) begin
            case (r_cmd)
                pct_pkg::CMD_ADD: begin
                    if (r_addr != '0) begin
                        res_acc          = 1'b1;
                        res_match        = r_hit;
                        res_idx          = r_hit ? r_hit_idx : r_ptr;
                        wr_en            = 1'b1;
                        wr_idx           = res_idx;
                        wr_data.used     = 1'b1;
                        wr_data.key_high = r_khi;
                        wr_data.key_low  = r_klo;
                        wr_data.addr     = r_addr;
                        ptr_load         = 1'b1;
                        ptr_next         = (res_idx == LAST) ? '0 : res_idx + 1'b1;
                    end
                end
                pct_pkg::CMD_REMOVE: begin
                    res_acc          = 1'b1;
                    res_match        = r_hit;
                    res_idx          = r_hit ? r_hit_idx : '0;
                    wr_en            = r_hit;
                    wr_data.key_high = r_hit_khi;
                    wr_data.key_low  = r_hit_klo;
                end
                pct_pkg::CMD_FLUSH: begin
                    res_acc  = 1'b1;
                    flush    = 1'b1;
                    ptr_load = 1'b1;
                    ptr_next = '0;
                end
                default: begin
                    res_acc = 1'b0;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pct_pkg::ST_IDLE;
            r_idx        <= '0;
            r_all_issued <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_hit        <= 1'b0;
            r_ptr        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= rd_en;
            if (in_beat) begin
                r_idx        <= '0;
                r_all_issued <= 1'b0;
                r_hit        <= 1'b0;
            end else if (rd_en) begin
                r_idx        <= (r_idx == LAST) ? r_idx : r_idx + 1'b1;
                r_all_issued <= (r_idx == LAST);
            end
            if ((r_state == pct_pkg::ST_SEARCH) && hit_now) begin
                r_hit <= 1'b1;
            end
            if (ptr_load) begin
                r_ptr <= ptr_next;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: command beat, search position, hit record, result.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_cmd  <= pct_pkg::t_cmd'(i_in.cmd);
            r_addr <= i_in.station_addr;
            r_khi  <= i_in.key_high;
            r_klo  <= i_in.key_low;
        end
        r_cmp_idx <= r_idx;
        if ((r_state == pct_pkg::ST_SEARCH) && hit_now) begin
            r_hit_idx <= r_cmp_idx;
            r_hit_khi <= rd_data.key_high;
            r_hit_klo <= rd_data.key_low;
        end
        if (finish) begin
            r_out_acc   <= res_acc;
            r_out_match <= res_match;
            r_out_slot  <= pct_pkg::SLOT_W'(res_idx);
        end
    end

    pct_entry_store #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_idx  (r_idx),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .i_flush   (flush)
    );

    assign i_in.ready     = (r_state == pct_pkg::ST_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.accepted = r_out_acc;
    assign o_out.matched  = r_out_match;
    assign o_out.slot     = r_out_slot;

`ifndef NO_ASSERTIONS
    // The replacement pointer never leaves the table.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= LAST)
        else $error("replacement pointer out of range");

    // A command taken from the input leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_state != pct_pkg::ST_IDLE))
        else $error("command taken without leaving idle");

    // Finishing with a free output register presents a result and returns to idle.
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_out_valid && (r_state == pct_pkg::ST_IDLE)))
        else $error("finished command produced no result");

    // A reported match always comes with an accepted operation.
    a_match_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.matched) |-> o_out.accepted)
        else $error("match reported on a rejected operation");

    // A hit is only recorded while searching.
    a_hit_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_hit) |-> ($past(r_state) == pct_pkg::ST_SEARCH))
        else $error("hit recorded outside the search");
`endif

endmodule

### tb/pct_cache_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the key-cache table: watches the command and result channels,
// predicts each result from its own copy of the table and compares them.
// It depends on pct_pkg and the channel interfaces in pct_if.
module pct_cache_checker #(
    parameter int ENTRIES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pct_in_if    i_cmd,
    pct_out_if   i_resp,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic                       accepted;
        logic                       matched;
        logic [pct_pkg::SLOT_W-1:0] slot;
    } t_cache_resp;

    // Shadow copy of the table and its replacement pointer.
    logic [pct_pkg::ADDR_W-1:0] tbl_addr [ENTRIES];
    logic [pct_pkg::KEY_W-1:0]  tbl_key_hi [ENTRIES];
    logic [pct_pkg::KEY_W-1:0]  tbl_key_lo [ENTRIES];
    logic                       tbl_used [ENTRIES];
    int                         next_ptr;

    t_cache_resp resp_q [$];
    int          fails = 0;

    function automatic void clear_table();
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_addr[i]   = '0;
            tbl_key_hi[i] = '0;
            tbl_key_lo[i] = '0;
            tbl_used[i]   = 1'b0;
        end
        next_ptr = 0;
    endfunction

    // Applies one command to the shadow table and returns the result it causes.
    function automatic t_cache_resp apply_cache_cmd(pct_pkg::t_cmd op,
                                                    logic [pct_pkg::ADDR_W-1:0] addr,
                                                    logic [pct_pkg::KEY_W-1:0] kh,
                                                    logic [pct_pkg::KEY_W-1:0] kl);
        t_cache_resp r;
        int          hit;
        int          w;
        r   = '0;
        hit = -1;
        // The lowest matching row wins, whether or not it is marked used.
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && tbl_addr[i] == addr)
                hit = i;
        end
        case (op)
            pct_pkg::CMD_ADD: begin
                // An all-zero address is refused and leaves the table alone.
                if (addr != '0) begin
                    r.accepted = 1'b1;
                    if (hit >= 0) begin
                        w         = hit;
                        r.matched = 1'b1;
                    end else begin
                        w           = next_ptr;
                        tbl_addr[w] = addr;
                    end
                    tbl_key_hi[w] = kh;
                    tbl_key_lo[w] = kl;
                    tbl_used[w]   = 1'b1;
                    next_ptr      = (w == ENTRIES - 1) ? 0 : w + 1;
                    r.slot        = w[pct_pkg::SLOT_W-1:0];
                end
            end
            pct_pkg::CMD_REMOVE: begin
                // The key stays behind; only the address and used mark go.
                r.accepted = 1'b1;
                if (hit >= 0) begin
                    tbl_addr[hit] = '0;
                    tbl_used[hit] = 1'b0;
                    r.matched     = 1'b1;
                    r.slot        = hit[pct_pkg::SLOT_W-1:0];
                end
            end
            pct_pkg::CMD_FLUSH: begin
                clear_table();
                r.accepted = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void note_mismatch(string what, int want, int got);
        fails++;
        if (fails <= 10)
            $display("%0t: mismatch on %s: expected %0d, got %0d",
                     $realtime, what, want, got);
    endfunction

    // Results are compared before the new command is recorded, so a beat on
    // each channel at one edge keeps the queue in order.
    always @(posedge i_clk) begin
        t_cache_resp got;
        t_cache_resp want;
        if (!i_rst_n) begin
            clear_table();
            resp_q.delete();
        end else begin
            if (i_resp.valid && i_resp.ready) begin
                got = '{accepted: i_resp.accepted, matched: i_resp.matched,
                        slot: i_resp.slot};
                if (resp_q.size() == 0) begin
                    note_mismatch("unexpected result beat", 0, 1);
                end else begin
                    want = resp_q.pop_front();
                    if (got.accepted !== want.accepted)
                        note_mismatch("accepted", want.accepted, got.accepted);
                    if (got.matched !== want.matched)
                        note_mismatch("matched", want.matched, got.matched);
                    if (got.slot !== want.slot)
                        note_mismatch("slot", want.slot, got.slot);
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                resp_q.push_back(apply_cache_cmd(pct_pkg::t_cmd'(i_cmd.cmd),
                                                 i_cmd.station_addr,
                                                 i_cmd.key_high, i_cmd.key_low));
        end
        o_pending    <= resp_q.size();
        o_fail_count <= fails;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Top of the key-cache table testbench: clock, reset, command stimulus and
// result back-pressure. It depends on pct_pkg, pct_if and pct_cache_checker.
module tb;

    localparam int ENTRIES     = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 900;
    localparam int POOL_SIZE   = 24;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   items_sent = 0;
    int   cycles = 0;
    bit   calm = 1'b0;
    bit   hold_done = 1'b0;

    pct_in_if  cmd_ch ();
    pct_out_if resp_ch ();

    pmkid_cache_table_top #(.ENTRIES(ENTRIES)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (resp_ch)
    );

    pct_cache_checker #(.ENTRIES(ENTRIES)) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_resp       (resp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [pct_pkg::KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [pct_pkg::ADDR_W-1:0] rand_addr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[pct_pkg::ADDR_W-1:0];
    endfunction

    // Offers one command beat, with random idle cycles ahead of it, and
    // returns at the falling edge after the beat has been taken.
    task automatic send_cmd(input pct_pkg::t_cmd op,
                            input logic [pct_pkg::ADDR_W-1:0] addr,
                            input logic [pct_pkg::KEY_W-1:0] kh,
                            input logic [pct_pkg::KEY_W-1:0] kl);
        while (!calm && $urandom_range(99) < 23) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.cmd          <= op;
        cmd_ch.station_addr <= addr;
        cmd_ch.key_high     <= kh;
        cmd_ch.key_low      <= kl;
        @(posedge i_clk);
        while (!cmd_ch.ready)
            @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Result side: random stalls, and one long hold-off once traffic is
    // flowing so that the block fills up and refuses commands.
    initial begin
        resp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && items_sent >= 150) begin
                hold_done = 1'b1;
                resp_ch.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end
            resp_ch.ready <= calm || ($urandom_range(99) >= 23);
        end
    end

    // Command stimulus and verdict.
    initial begin
        logic [pct_pkg::ADDR_W-1:0] pool [POOL_SIZE];
        logic [pct_pkg::ADDR_W-1:0] addr;
        pct_pkg::t_cmd              op;
        int                         r;
        i_rst_n             = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.cmd          = pct_pkg::CMD_NOP;
        cmd_ch.station_addr = '0;
        cmd_ch.key_high     = '0;
        cmd_ch.key_low      = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: refused commands, the zero address on an empty table,
        // field extremes, hit and miss for add and remove, then flush.
        send_cmd(pct_pkg::CMD_NOP, '1, '1, '1);
        send_cmd(pct_pkg::CMD_ADD, '0, '1, '1);
        send_cmd(pct_pkg::CMD_REMOVE, '0, '0, '0);
        send_cmd(pct_pkg::CMD_ADD, '1, '1, '1);
        send_cmd(pct_pkg::CMD_ADD, 48'd1, '0, '0);
        send_cmd(pct_pkg::CMD_ADD, '1, 64'hA5A5_5A5A_0F0F_F0F0, 64'h0123_4567_89AB_CDEF);
        send_cmd(pct_pkg::CMD_REMOVE, '1, '0, '0);
        send_cmd(pct_pkg::CMD_REMOVE, '1, '1, '1);
        send_cmd(pct_pkg::CMD_FLUSH, rand_addr(), rand_key(), rand_key());

        // Fill every row, overwrite at the pointer, hit in the last row so the
        // pointer wraps, then look for the zero address in a full table.
        for (int i = 0; i < ENTRIES; i++)
            send_cmd(pct_pkg::CMD_ADD, 48'h0C3_0000_0000 + pct_pkg::ADDR_W'(i + 1),
                     rand_key(), rand_key());
        send_cmd(pct_pkg::CMD_ADD, 48'h5A5_0000_0001, rand_key(), rand_key());
        send_cmd(pct_pkg::CMD_ADD, 48'h0C3_0000_0000 + pct_pkg::ADDR_W'(ENTRIES),
                 rand_key(), rand_key());
        send_cmd(pct_pkg::CMD_ADD, 48'h5A5_0000_0002, rand_key(), rand_key());
        send_cmd(pct_pkg::CMD_REMOVE, '0, rand_key(), rand_key());

        // Random: a small pool of addresses keeps hits, replacement and
        // removal frequent, with some fresh and zero addresses mixed in.
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool[i] = rand_addr();
            if (pool[i] == '0)
                pool[i] = 48'd1;
        end
        for (int n = 0; n < RAND_ITEMS; n++) begin
            calm = (n >= 400 && n < 550);
            r = $urandom_range(99);
            if (r < 58)
                op = pct_pkg::CMD_ADD;
            else if (r < 92)
                op = pct_pkg::CMD_REMOVE;
            else if (r < 94)
                op = pct_pkg::CMD_FLUSH;
            else
                op = pct_pkg::CMD_NOP;
            r = $urandom_range(99);
            if (r < 4)
                addr = '0;
            else if (r < 14)
                addr = rand_addr();
            else
                addr = pool[$urandom_range(POOL_SIZE - 1)];
            send_cmd(op, addr, rand_key(), rand_key());
        end
        calm = 1'b0;
        cmd_ch.valid <= 1'b0;

        // Drain, then leave room for any stray beat to show up.
        while (pending != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
